// ----- rtl/tdr_pkg.sv -----
// Shared types and constants of the touch report decoder.
package tdr_pkg;

  // One 8-byte event report as it arrives from the touch controller.
  typedef struct packed {
    logic [7:0] report_byte0;
    logic [7:0] report_byte1;
    logic [7:0] report_byte2;
    logic [7:0] report_byte3;
    logic [7:0] report_byte4;
    logic [7:0] report_byte5;
    logic [7:0] report_byte6;
    logic [7:0] report_byte7;
  } report_t;

  // One decoded result.
  typedef struct packed {
    logic [3:0]  event_kind;
    logic        touching;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [15:0] pressure;
    logic [4:0]  finger_count;
  } result_t;

  // Divider widths: the remainder stays below the largest area divisor (126).
  localparam int unsigned DivW  = 7;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned StepW = 5;

  // Request to the divider. The dividend is split into an initial
  // partial remainder and the bits still to be shifted in, MSB first.
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  rem0;
    logic [QuoW-1:0]  bits;
    logic [DivW-1:0]  divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CODE_ENTER  = 3'd0;
  localparam logic [2:0] CFG_CODE_MOTION = 3'd1;
  localparam logic [2:0] CFG_CODE_LEAVE  = 3'd2;
  localparam logic [2:0] CFG_CODE_NONE   = 3'd3;
  localparam logic [2:0] CFG_PALM_LIMIT  = 3'd4;

  // Panel geometry and scaling.
  localparam int unsigned EdgeLo    = 15;
  localparam int unsigned XTop      = 1264;
  localparam int unsigned YTop      = 704;
  localparam int unsigned ScaleDiv  = 1000;
  localparam int unsigned GainX     = (1280 * 1000) / (XTop - EdgeLo);
  localparam int unsigned GainY     = (720 * 1000) / (YTop - EdgeLo);
  localparam int unsigned AreaMax   = 63;
  localparam int unsigned AreaBias  = 64;

  // The division of a scaled axis by ScaleDiv is a multiplication by the
  // rounded-up reciprocal times 2^ScaleShift. It is exact for every
  // product below 2^21, which covers both axes.
  localparam int unsigned       ScaleShift = 31;
  localparam longint unsigned   ScaleRecip =
    ((64'd1 << ScaleShift) + ScaleDiv - 1) / ScaleDiv;
  localparam longint unsigned   MulX       = GainX * ScaleRecip;
  localparam longint unsigned   MulY       = GainY * ScaleRecip;

endpackage

// ----- rtl/touch_report_decoder.sv -----
// Top level of the touch report decoder: sequencer, held contact and registers.
//
// The block takes one 8-byte touch event report per input transfer and gives
// one decoded result per report. An enter or motion report has its result
// ready after a decode state, a restoring divider that produces one bit of
// the normalized pressure per cycle, and a state that picks up the quotient.
// The screen x and y are clamped, offset and scaled combinationally, the
// division by 1000 being a multiplication by a reciprocal, so they add no
// time. Leave, empty and unknown reports have their result one cycle after
// the transfer. Input ready is high only while no report is in progress and
// no result is waiting, so one report is worked on at a time; a new report
// is taken only after the result of the last one has been taken.
// Configuration is written through the plain write port (index 0 to 4:
// enter, motion, leave and none codes, palm limit); an index outside that
// range is ignored. The held position, pressure, finger count and touch flag
// persist between reports and are cleared by reset.
module touch_report_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdr_pkg::report_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tdr_pkg::result_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_DIVZ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;

  // Configuration registers.
  logic [3:0]  code_enter_q, code_motion_q, code_leave_q, code_none_q;
  logic [15:0] palm_limit_q;

  // Held contact.
  logic        active_q, active_d;
  logic [10:0] held_x_q, held_x_d;
  logic [9:0]  held_y_q, held_y_d;
  logic [15:0] held_p_q, held_p_d;
  logic [4:0]  held_f_q, held_f_d;

  // Working registers for the report in progress.
  tdr_pkg::report_t rep_q;
  tdr_pkg::result_t res_q, res_d;

  tdr_pkg::div_req_t div_req;
  logic              div_done;
  logic [15:0]       div_quo;

  // Decode of the latched report.
  logic [3:0]  ev_id;
  logic        is_contact, is_leave, is_none;
  logic [11:0] raw_x, raw_y;
  logic [11:0] x_clamp, y_clamp;
  logic [10:0] x_off;
  logic [9:0]  y_off;
  logic [41:0] x_prod_full;
  logic [40:0] y_prod_full;
  logic [10:0] x_scaled;
  logic [9:0]  y_scaled;
  logic [4:0]  fingers_new;
  logic [5:0]  area;
  logic [6:0]  divisor_z;

  assign ev_id      = rep_q.report_byte1[3:0];
  assign is_contact = (ev_id == code_enter_q) || (ev_id == code_motion_q);
  assign is_leave   = (ev_id == code_leave_q);
  assign is_none    = (ev_id == code_none_q);

  assign raw_x = {rep_q.report_byte2, rep_q.report_byte4[7:4]};
  assign raw_y = {rep_q.report_byte3, rep_q.report_byte4[3:0]};

  // Clamp each axis to the panel's active area before the offset.
  always_comb begin
    if (raw_x < 12'(tdr_pkg::EdgeLo)) begin
      x_clamp = 12'(tdr_pkg::EdgeLo);
    end else if (raw_x > 12'(tdr_pkg::XTop)) begin
      x_clamp = 12'(tdr_pkg::XTop);
    end else begin
      x_clamp = raw_x;
    end
    if (raw_y < 12'(tdr_pkg::EdgeLo)) begin
      y_clamp = 12'(tdr_pkg::EdgeLo);
    end else if (raw_y > 12'(tdr_pkg::YTop)) begin
      y_clamp = 12'(tdr_pkg::YTop);
    end else begin
      y_clamp = raw_y;
    end
  end

  assign x_off = 11'(x_clamp - 12'(tdr_pkg::EdgeLo));
  assign y_off = 10'(y_clamp - 12'(tdr_pkg::EdgeLo));

  // Gain and division by 1000 folded into one constant multiplication; the
  // screen coordinate sits above the reciprocal's fraction bits.
  assign x_prod_full = 42'(x_off) * 42'(tdr_pkg::MulX);
  assign y_prod_full = 41'(y_off) * 41'(tdr_pkg::MulY);
  assign x_scaled    = x_prod_full[tdr_pkg::ScaleShift +: 11];
  assign y_scaled    = y_prod_full[tdr_pkg::ScaleShift +: 10];

  assign fingers_new = 5'(rep_q.report_byte1[7:4]) + 5'd1;

  // An area of one or of the full six-bit value counts as no area at all.
  always_comb begin
    area = rep_q.report_byte7[5:0];
    if (area == 6'd1 || area == 6'(tdr_pkg::AreaMax)) begin
      area = 6'd0;
    end
  end
  assign divisor_z = 7'(area) + 7'(tdr_pkg::AreaBias);

  tdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer. The divider request is issued on leaving the decode state;
  // the quotient is picked up in the cycle its done pulse is seen.
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    held_p_d = held_p_q;
    held_f_d = held_f_q;
    res_d    = res_q;
    div_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        res_d.touching     = active_q;
        res_d.pos_x        = held_x_q;
        res_d.pos_y        = held_y_q;
        res_d.pressure     = held_p_q;
        res_d.finger_count = held_f_q;
        if (is_contact) begin
          // Pressure: (raw << 6) / divisor, a 22-bit dividend whose quotient
          // always fits in 16 bits, so its top six bits start the remainder.
          div_req.start   = 1'b1;
          div_req.rem0    = 7'(rep_q.report_byte6[7:2]);
          div_req.bits    = {rep_q.report_byte6[1:0], rep_q.report_byte5, 6'd0};
          div_req.divisor = divisor_z;
          div_req.steps   = 5'(tdr_pkg::QuoW);
          state_d         = S_DIVZ;
        end else if (is_leave) begin
          // Leave report: refresh x, drop the contact and the finger count.
          active_d           = 1'b0;
          held_f_d           = 5'd0;
          held_x_d           = x_scaled;
          res_d.event_kind   = ev_id;
          res_d.touching     = 1'b0;
          res_d.pos_x        = x_scaled;
          res_d.finger_count = 5'd0;
          state_d            = S_OUT;
        end else if (is_none) begin
          res_d.event_kind = active_q ? code_motion_q : ev_id;
          state_d          = S_OUT;
        end else begin
          // Unknown report: the prior event id in byte 0 and the touch flag decide.
          if (active_q && (rep_q.report_byte0 == {4'd0, code_motion_q})) begin
            res_d.event_kind = code_motion_q;
          end else begin
            res_d.event_kind = code_leave_q;
          end
          state_d = S_OUT;
        end
      end

      S_DIVZ: begin
        if (div_done) begin
          // Contact report: everything is stored, and a pressure at or above
          // the palm limit turns the event into a leave.
          held_p_d = div_quo;
          held_f_d = fingers_new;
          held_x_d = x_scaled;
          held_y_d = y_scaled;
          if (div_quo < palm_limit_q) begin
            active_d         = 1'b1;
            res_d.event_kind = ev_id;
          end else begin
            active_d         = 1'b0;
            res_d.event_kind = code_leave_q;
          end
          res_d.touching     = (div_quo < palm_limit_q);
          res_d.pos_x        = x_scaled;
          res_d.pos_y        = y_scaled;
          res_d.pressure     = div_quo;
          res_d.finger_count = fingers_new;
          state_d            = S_OUT;
        end
      end

      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  // Control state, configuration and the held contact.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      code_enter_q  <= 4'd3;
      code_motion_q <= 4'd4;
      code_leave_q  <= 4'd5;
      code_none_q   <= 4'd0;
      palm_limit_q  <= 16'd255;
      active_q      <= 1'b0;
      held_x_q      <= '0;
      held_y_q      <= '0;
      held_p_q      <= '0;
      held_f_q      <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
      held_p_q <= held_p_d;
      held_f_q <= held_f_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tdr_pkg::CFG_CODE_ENTER:  code_enter_q  <= cfg_wdata_i[3:0];
          tdr_pkg::CFG_CODE_MOTION: code_motion_q <= cfg_wdata_i[3:0];
          tdr_pkg::CFG_CODE_LEAVE:  code_leave_q  <= cfg_wdata_i[3:0];
          tdr_pkg::CFG_CODE_NONE:   code_none_q   <= cfg_wdata_i[3:0];
          tdr_pkg::CFG_PALM_LIMIT:  palm_limit_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rep_q <= in_data_i;
    end
    res_q <= res_d;
  end

endmodule

// ----- rtl/tdr_div.sv -----
// Restoring divider, one quotient bit per clock cycle.
module tdr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tdr_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [tdr_pkg::QuoW-1:0]    quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tdr_pkg::StepW-1:0]     cnt_q, cnt_d;
  logic [tdr_pkg::DivW-1:0]      rem_q, rem_d;
  logic [tdr_pkg::DivW-1:0]      dvs_q, dvs_d;
  logic [tdr_pkg::QuoW-1:0]      bits_q, bits_d;
  logic [tdr_pkg::QuoW-1:0]      quo_q, quo_d;
  logic [tdr_pkg::DivW:0]        partial;
  logic [tdr_pkg::DivW:0]        trial;

  assign partial = {rem_q, bits_q[tdr_pkg::QuoW-1]};
  assign trial   = partial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem0;
      dvs_d  = req_i.divisor;
      bits_d = req_i.bits;
      quo_d  = '0;
    end else if (busy_q) begin
      bits_d = {bits_q[tdr_pkg::QuoW-2:0], 1'b0};
      if (partial >= {1'b0, dvs_q}) begin
        rem_d = trial[tdr_pkg::DivW-1:0];
        quo_d = {quo_q[tdr_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = partial[tdr_pkg::DivW-1:0];
        quo_d = {quo_q[tdr_pkg::QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tdr_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
